// ===== rtl/tts_pkg.sv =====
// Package for the triangle to trapezoid splitter.
// Field widths, transaction structs and internal pipeline types.
// No dependencies.
package tts_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned INDEX_WIDTH = 24;
  localparam int unsigned DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH  = 2 * DIFF_WIDTH;

  typedef logic        [INDEX_WIDTH-1:0] index_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  typedef struct packed {
    index_t primitive_index;
    index_t vertex_a_index;
    index_t vertex_b_index;
    index_t vertex_c_index;
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
  } tri_in_t;

  typedef struct packed {
    index_t tag_primitive;
    index_t left_start_index;
    index_t left_end_index;
    index_t right_start_index;
    index_t right_end_index;
    coord_t top_y;
    coord_t bottom_y;
    logic   last_piece;
  } trap_out_t;

  typedef struct packed {
    index_t idx;
    coord_t x;
    coord_t y;
  } vert_t;

endpackage

// ===== rtl/triangle_trapezoid_split.sv =====
// Triangle to trapezoid splitter, top level.
// Four-stage pipeline: input register, y sort, side-test products, piece output.
// Depends on tts_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_i carries one triangle per
//   transaction. Output channel out_valid_o / out_stall_i / out_o carries one
//   trapezoid per transaction; last_piece marks the final one of a triangle.
//   Degenerate triangles (all x equal or all y equal) produce nothing.
//   The input transaction passes through the input, sort, product and piece
//   registers in turn before the first trapezoid is offered.
//   Throughput: one triangle per cycle while out_stall_i is low and it yields
//   one trapezoid; one that yields two holds the output stage, which sends
//   both pieces in turn, until its second piece is taken.
//   The input is taken while earlier triangles are in flight; each stage moves
//   on as soon as the stage after it is free or emptying in the same cycle.
//   When out_stall_i is high the offered trapezoid holds, the pipeline fills
//   up and in_stall_o rises once all stages are occupied.
//   Reset empties all stages; no output is offered until new input arrives.
module triangle_trapezoid_split
  import tts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tri_in_t   in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output trap_out_t out_o
);

  // stage valid bits and payloads
  logic      a_valid_q, b_valid_q, c_valid_q, d_valid_q;
  tri_in_t   a_q;
  vert_t     b_v0_q, b_v1_q, b_v2_q;
  index_t    b_tag_q;
  vert_t     c_v0_q, c_v1_q, c_v2_q;
  index_t    c_tag_q;
  prod_t     c_pl_q, c_pr_q;
  trap_out_t d_p0_q, d_p1_q;
  logic      d_two_q;
  logic      d_sel_q, d_sel_d;

  logic a_ready, b_ready, c_ready, d_ready;
  logic out_fire, d_done;

  assign out_fire = d_valid_q && !out_stall_i;
  assign d_done   = out_fire && (!d_two_q || d_sel_q);
  assign d_ready  = !d_valid_q || d_done;
  assign c_ready  = !c_valid_q || d_ready;
  assign b_ready  = !b_valid_q || c_ready;
  assign a_ready  = !a_valid_q || b_ready;

  assign in_stall_o = !a_ready;

  // stage A -> B: degenerate test and stable sort by descending y
  vert_t s0, s1, s2, tmp;
  logic  degen;

  always_comb begin
    s0 = '{idx: a_q.vertex_a_index, x: a_q.vertex_a_x, y: a_q.vertex_a_y};
    s1 = '{idx: a_q.vertex_b_index, x: a_q.vertex_b_x, y: a_q.vertex_b_y};
    s2 = '{idx: a_q.vertex_c_index, x: a_q.vertex_c_x, y: a_q.vertex_c_y};
    degen = ((a_q.vertex_a_x == a_q.vertex_b_x) && (a_q.vertex_a_x == a_q.vertex_c_x)) ||
            ((a_q.vertex_a_y == a_q.vertex_b_y) && (a_q.vertex_a_y == a_q.vertex_c_y));
    tmp = s0;
    if (s0.y < s1.y) begin
      tmp = s0;
      s0  = s1;
      s1  = tmp;
    end
    if (s1.y < s2.y) begin
      tmp = s1;
      s1  = s2;
      s2  = tmp;
    end
    if (s0.y < s1.y) begin
      tmp = s0;
      s0  = s1;
      s1  = tmp;
    end
  end

  // stage B -> C: edge differences and side-test products
  diff_t dy1, dx2, dx1, dy2;
  prod_t pl_d, pr_d;

  always_comb begin
    dy1  = DIFF_WIDTH'(b_v1_q.y) - DIFF_WIDTH'(b_v0_q.y);
    dx2  = DIFF_WIDTH'(b_v2_q.x) - DIFF_WIDTH'(b_v0_q.x);
    dx1  = DIFF_WIDTH'(b_v1_q.x) - DIFF_WIDTH'(b_v0_q.x);
    dy2  = DIFF_WIDTH'(b_v2_q.y) - DIFF_WIDTH'(b_v0_q.y);
    pl_d = PROD_WIDTH'(dy1) * PROD_WIDTH'(dx2);
    pr_d = PROD_WIDTH'(dx1) * PROD_WIDTH'(dy2);
  end

  // stage C -> D: build the pieces
  trap_out_t p0_d, p1_d;
  logic      two_d;
  vert_t     lv, rv;

  always_comb begin
    lv    = c_v0_q;
    rv    = c_v1_q;
    two_d = 1'b0;
    p0_d  = '0;
    p1_d  = '0;
    priority if (c_v0_q.y == c_v1_q.y) begin
      if (c_v0_q.x > c_v1_q.x) begin
        lv = c_v1_q;
        rv = c_v0_q;
      end
      p0_d = '{c_tag_q, lv.idx, c_v2_q.idx, rv.idx, c_v2_q.idx,
               c_v0_q.y, c_v2_q.y, 1'b1};
    end else if (c_v1_q.y == c_v2_q.y) begin
      lv = c_v1_q;
      rv = c_v2_q;
      if (c_v1_q.x > c_v2_q.x) begin
        lv = c_v2_q;
        rv = c_v1_q;
      end
      p0_d = '{c_tag_q, c_v0_q.idx, lv.idx, c_v0_q.idx, rv.idx,
               c_v0_q.y, c_v2_q.y, 1'b1};
    end else if (c_pl_q > c_pr_q) begin
      // long edge on the left
      two_d = 1'b1;
      p0_d  = '{c_tag_q, c_v0_q.idx, c_v2_q.idx, c_v0_q.idx, c_v1_q.idx,
                c_v0_q.y, c_v1_q.y, 1'b0};
      p1_d  = '{c_tag_q, c_v0_q.idx, c_v2_q.idx, c_v1_q.idx, c_v2_q.idx,
                c_v1_q.y, c_v2_q.y, 1'b1};
    end else begin
      two_d = 1'b1;
      p0_d  = '{c_tag_q, c_v0_q.idx, c_v1_q.idx, c_v0_q.idx, c_v2_q.idx,
                c_v0_q.y, c_v1_q.y, 1'b0};
      p1_d  = '{c_tag_q, c_v1_q.idx, c_v2_q.idx, c_v0_q.idx, c_v2_q.idx,
                c_v1_q.y, c_v2_q.y, 1'b1};
    end
  end

  always_comb begin
    d_sel_d = d_sel_q;
    if (out_fire) begin
      d_sel_d = !d_done;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      d_sel_q   <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q && !degen;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
      d_sel_q <= d_sel_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_q <= in_i;
    end
    if (b_ready && a_valid_q) begin
      b_v0_q  <= s0;
      b_v1_q  <= s1;
      b_v2_q  <= s2;
      b_tag_q <= a_q.primitive_index;
    end
    if (c_ready && b_valid_q) begin
      c_v0_q  <= b_v0_q;
      c_v1_q  <= b_v1_q;
      c_v2_q  <= b_v2_q;
      c_tag_q <= b_tag_q;
      c_pl_q  <= pl_d;
      c_pr_q  <= pr_d;
    end
    if (d_ready && c_valid_q) begin
      d_p0_q  <= p0_d;
      d_p1_q  <= p1_d;
      d_two_q <= two_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_o       = d_sel_q ? d_p1_q : d_p0_q;

endmodule
